// File: rtl/core/assert_macros.svh
// assertion helpers for the table block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/skt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types, codes and sizes for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;
	localparam int TableDepthDefault = 64;
	localparam int KeyW   = 27;
	localparam int GradeW = 10;
	localparam int PosW   = 7;

	localparam logic [2:0] CMD_INSERT  = 3'd0;
	localparam logic [2:0] CMD_DELETE  = 3'd1;
	localparam logic [2:0] CMD_UPD_KEY = 3'd2;
	localparam logic [2:0] CMD_UPD_IDX = 3'd3;
	localparam logic [2:0] CMD_LOOKUP  = 3'd4;
	localparam logic [2:0] CMD_READ    = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BADINDEX = 2'd2;
	localparam logic [1:0] ST_NOKEY    = 2'd3;

	typedef struct packed {
		logic [2:0]        command;
		logic [KeyW-1:0]   key;
		logic [PosW-1:0]   position;
		logic              has_grade;
		logic [GradeW-1:0] grade;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [KeyW-1:0]   entry_key;
		logic              entry_has_grade;
		logic [GradeW-1:0] entry_grade;
		logic [PosW-1:0]   count;
		logic              max_valid;
		logic [KeyW-1:0]   max_key;
		logic [GradeW-1:0] max_grade;
	} rsp_t;

	typedef struct packed {
		logic              has_grade;
		logic [GradeW-1:0] grade;
		logic [KeyW-1:0]   key;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_BS_RD, S_BS,
		S_WRITE, S_RD_RD, S_RD, S_MAX_RD, S_MAX, S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_req;
		logic ptr_count;   // ptr <= count (insert from top)
		logic ptr_zero;    // ptr <= 0
		logic ptr_pos;     // ptr <= position - 1
		logic ptr_inc;
		logic ptr_dec;
		logic bs_init;
		logic bs_step;
		logic ptr_mid;
		logic rd_ptr;      // read entry at ptr
		logic rd_ptr_m1;   // read entry at ptr - 1
		logic rd_ptr_p1;   // read entry at ptr + 1
		logic wr_shift;    // write read data to ptr
		logic wr_new;      // write request entry to ptr
		logic cnt_inc;
		logic cnt_dec;
		logic set_status;
		logic [1:0] status;
		logic cap_entry;
		logic max_clear;
		logic max_step;
		logic load_rsp;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] command;
		logic full;
		logic pos_bad;
		logic ptr_zero;       // count == 0
		logic ptr_at_end;     // count == 0
		logic ptr_last;       // ptr + 1 >= count (insert: ptr <= 1)
		logic key_gt_rd;      // req key > read key
		logic key_eq_rd;
		logic bs_done;        // lo > hi
		logic ptr_max_done;   // scan ptr >= count
	} sts_t;
endpackage
`default_nettype wire

// File: rtl/core/skt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skt_ctrl
// Command sequencer for the sorted key table.
// ----------------------------------------------------------------------------
module skt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          rsp_free,
	input  wire skt_pkg::sts_t sts,
	output skt_pkg::cmd_t      cmd
);
	skt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= skt_pkg::S_IDLE;
		else state_q <= state_d;
	end

	assign in_ready = (state_q == skt_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			skt_pkg::S_IDLE: if (in_valid) state_d = skt_pkg::S_DECODE;
			skt_pkg::S_DECODE: begin
				case (sts.command)
					skt_pkg::CMD_INSERT:
						state_d = sts.full ? skt_pkg::S_MAX_RD :
							(sts.ptr_zero ? skt_pkg::S_WRITE : skt_pkg::S_SHIFT_RD);
					skt_pkg::CMD_DELETE:
						state_d = sts.ptr_at_end ? skt_pkg::S_MAX_RD : skt_pkg::S_SCAN_RD;
					skt_pkg::CMD_UPD_KEY, skt_pkg::CMD_LOOKUP: state_d = skt_pkg::S_BS;
					skt_pkg::CMD_UPD_IDX:
						state_d = sts.pos_bad ? skt_pkg::S_MAX_RD : skt_pkg::S_WRITE;
					skt_pkg::CMD_READ:
						state_d = sts.pos_bad ? skt_pkg::S_MAX_RD : skt_pkg::S_RD_RD;
					default: state_d = skt_pkg::S_MAX_RD;
				endcase
			end
			skt_pkg::S_SCAN_RD: state_d = skt_pkg::S_SCAN;
			skt_pkg::S_SCAN: begin
				if (sts.key_eq_rd)
					state_d = sts.ptr_last ? skt_pkg::S_MAX_RD : skt_pkg::S_SHIFT_RD;
				else if (sts.ptr_last) state_d = skt_pkg::S_MAX_RD;
				else state_d = skt_pkg::S_SCAN_RD;
			end
			skt_pkg::S_SHIFT_RD: state_d = skt_pkg::S_SHIFT_WR;
			skt_pkg::S_SHIFT_WR: begin
				if (sts.command == skt_pkg::CMD_INSERT) begin
					if (sts.key_gt_rd) state_d = skt_pkg::S_WRITE;
					else state_d = sts.ptr_last ? skt_pkg::S_WRITE : skt_pkg::S_SHIFT_RD;
				end else begin
					state_d = sts.ptr_last ? skt_pkg::S_MAX_RD : skt_pkg::S_SHIFT_RD;
				end
			end
			skt_pkg::S_BS: state_d = sts.bs_done ? skt_pkg::S_MAX_RD : skt_pkg::S_BS_RD;
			skt_pkg::S_BS_RD: begin
				if (sts.key_eq_rd)
					state_d = (sts.command == skt_pkg::CMD_LOOKUP) ? skt_pkg::S_RD :
						skt_pkg::S_WRITE;
				else state_d = skt_pkg::S_BS;
			end
			skt_pkg::S_WRITE: state_d = skt_pkg::S_MAX_RD;
			skt_pkg::S_RD_RD: state_d = skt_pkg::S_RD;
			skt_pkg::S_RD: state_d = skt_pkg::S_MAX_RD;
			skt_pkg::S_MAX_RD: state_d = sts.ptr_max_done ? skt_pkg::S_DONE : skt_pkg::S_MAX;
			skt_pkg::S_MAX: state_d = skt_pkg::S_MAX_RD;
			skt_pkg::S_DONE: if (rsp_free) state_d = skt_pkg::S_IDLE;
			default: state_d = skt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			skt_pkg::S_IDLE: cmd.load_req = in_valid;
			skt_pkg::S_DECODE: begin
				case (sts.command)
					skt_pkg::CMD_INSERT: begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status = skt_pkg::ST_FULL;
						end else cmd.ptr_count = 1'b1;
					end
					skt_pkg::CMD_DELETE: begin
						cmd.ptr_zero = 1'b1;
						if (sts.ptr_at_end) begin
							cmd.set_status = 1'b1;
							cmd.status = skt_pkg::ST_NOKEY;
						end
					end
					skt_pkg::CMD_UPD_KEY, skt_pkg::CMD_LOOKUP: cmd.bs_init = 1'b1;
					skt_pkg::CMD_UPD_IDX, skt_pkg::CMD_READ: begin
						if (sts.pos_bad) begin
							cmd.set_status = 1'b1;
							cmd.status = skt_pkg::ST_BADINDEX;
						end else cmd.ptr_pos = 1'b1;
					end
					default: ;
				endcase
			end
			skt_pkg::S_SCAN_RD: cmd.rd_ptr = 1'b1;
			skt_pkg::S_SCAN: begin
				if (sts.key_eq_rd) begin
					if (sts.ptr_last) cmd.cnt_dec = 1'b1;
				end else if (sts.ptr_last) begin
					cmd.set_status = 1'b1;
					cmd.status = skt_pkg::ST_NOKEY;
				end else cmd.ptr_inc = 1'b1;
			end
			skt_pkg::S_SHIFT_RD: begin
				if (sts.command == skt_pkg::CMD_INSERT) cmd.rd_ptr_m1 = 1'b1;
				else cmd.rd_ptr_p1 = 1'b1;
			end
			skt_pkg::S_SHIFT_WR: begin
				if (sts.command == skt_pkg::CMD_INSERT) begin
					if (!sts.key_gt_rd) begin
						cmd.wr_shift = 1'b1;
						cmd.ptr_dec = 1'b1;
					end
				end else begin
					cmd.wr_shift = 1'b1;
					cmd.ptr_inc = 1'b1;
					if (sts.ptr_last) cmd.cnt_dec = 1'b1;
				end
			end
			skt_pkg::S_BS: begin
				if (sts.bs_done) begin
					cmd.set_status = 1'b1;
					cmd.status = skt_pkg::ST_NOKEY;
				end else cmd.ptr_mid = 1'b1;
			end
			skt_pkg::S_BS_RD: if (!sts.key_eq_rd) cmd.bs_step = 1'b1;
			skt_pkg::S_WRITE: begin
				cmd.wr_new = 1'b1;
				if (sts.command == skt_pkg::CMD_INSERT) cmd.cnt_inc = 1'b1;
			end
			skt_pkg::S_RD_RD: cmd.rd_ptr = 1'b1;
			skt_pkg::S_RD: cmd.cap_entry = 1'b1;
			skt_pkg::S_MAX_RD: begin
				cmd.rd_ptr = 1'b1;
			end
			skt_pkg::S_MAX: begin
				cmd.max_step = 1'b1;
				cmd.ptr_inc = 1'b1;
			end
			skt_pkg::S_DONE: cmd.load_rsp = rsp_free;
			default: ;
		endcase
		// the max scan restarts from zero whenever the command phase ends
		if (state_d == skt_pkg::S_MAX_RD && state_q != skt_pkg::S_MAX_RD &&
				state_q != skt_pkg::S_MAX) begin
			cmd.max_clear = 1'b1;
			cmd.ptr_zero = 1'b1;
			cmd.ptr_inc = 1'b0;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/skt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skt_datapath
// Entry memory, pointers, search bounds and running maximum.
// ----------------------------------------------------------------------------
module skt_datapath #(
	parameter int TABLE_DEPTH = skt_pkg::TableDepthDefault
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire skt_pkg::req_t req,
	input  wire skt_pkg::cmd_t cmd,
	output skt_pkg::sts_t      sts,
	output skt_pkg::rsp_t      rsp_d
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int PW = CW + 1;

	skt_pkg::entry_t mem [TABLE_DEPTH];
	skt_pkg::entry_t rd_q;
	skt_pkg::req_t   req_q;
	logic [CW-1:0]   count_q;
	logic [PW-1:0]   ptr_q, lo_q, hi_q; // signed view for hi = -1
	logic [1:0]      status_q;
	skt_pkg::entry_t ent_q, max_q;
	logic            ent_ok_q, max_ok_q;

	logic [PW-1:0] count_x, ptr_m1, ptr_p1, mid, rd_addr;
	logic          rd_en;

	assign count_x = PW'(count_q);
	assign ptr_m1  = ptr_q - PW'(1);
	assign ptr_p1  = ptr_q + PW'(1);
	assign mid     = PW'((CW + 2)'(lo_q) + (CW + 2)'(hi_q) >> 1);

	always_comb begin
		rd_en = cmd.rd_ptr | cmd.rd_ptr_m1 | cmd.rd_ptr_p1 | cmd.ptr_mid;
		if (cmd.rd_ptr_m1) rd_addr = ptr_m1;
		else if (cmd.rd_ptr_p1) rd_addr = ptr_p1;
		else if (cmd.ptr_mid) rd_addr = mid;
		else rd_addr = ptr_q;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem[rd_addr[AW-1:0]];
		if (cmd.wr_shift) mem[ptr_q[AW-1:0]] <= rd_q;
		else if (cmd.wr_new)
			mem[ptr_q[AW-1:0]] <= '{has_grade: req_q.has_grade,
				grade: req_q.has_grade ? req_q.grade : '0, key: req_q.key};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q    <= req;
			status_q <= skt_pkg::ST_OK;
			ent_ok_q <= 1'b0;
		end
		if (cmd.set_status) status_q <= cmd.status;
		if (cmd.ptr_zero) ptr_q <= '0;
		else if (cmd.ptr_count) ptr_q <= count_x;
		else if (cmd.ptr_pos) ptr_q <= PW'(req_q.position) - PW'(1);
		else if (cmd.ptr_mid) ptr_q <= mid;
		else if (cmd.ptr_inc) ptr_q <= ptr_p1;
		else if (cmd.ptr_dec) ptr_q <= ptr_m1;
		if (cmd.bs_init) begin
			lo_q <= '0;
			hi_q <= count_x - PW'(1);
		end else if (cmd.bs_step) begin
			if (req_q.key < rd_q.key) hi_q <= ptr_q - PW'(1);
			else lo_q <= ptr_q + PW'(1);
		end
		if (cmd.cap_entry) begin
			ent_q    <= rd_q;
			ent_ok_q <= 1'b1;
		end
		if (cmd.max_clear) max_ok_q <= 1'b0;
		else if (cmd.max_step && rd_q.has_grade) begin
			if (!max_ok_q || rd_q.grade > max_q.grade ||
					(rd_q.grade == max_q.grade && rd_q.key < max_q.key)) begin
				max_ok_q <= 1'b1;
				max_q    <= rd_q;
			end
		end
	end

	always_comb begin
		sts.command      = req_q.command;
		sts.full         = (count_x >= PW'(TABLE_DEPTH));
		sts.pos_bad      = (req_q.position == '0) || (PW'(req_q.position) > count_x);
		sts.ptr_zero     = (count_q == '0);
		sts.ptr_at_end   = (count_q == '0);
		sts.ptr_last     = (ptr_p1 >= count_x);
		sts.key_gt_rd    = (req_q.key > rd_q.key);
		sts.key_eq_rd    = (req_q.key == rd_q.key);
		sts.bs_done      = ($signed(lo_q) > $signed(hi_q));
		sts.ptr_max_done = (ptr_q >= count_x);
		// insert: stop shifting when ptr reaches zero after this step
		if (req_q.command == skt_pkg::CMD_INSERT) sts.ptr_last = (ptr_q <= PW'(1));
	end

	always_comb begin
		rsp_d.status          = status_q;
		rsp_d.entry_key       = ent_ok_q ? ent_q.key : '0;
		rsp_d.entry_has_grade = ent_ok_q ? ent_q.has_grade : 1'b0;
		rsp_d.entry_grade     = ent_ok_q ? ent_q.grade : '0;
		rsp_d.count           = skt_pkg::PosW'(count_q);
		rsp_d.max_valid       = max_ok_q;
		rsp_d.max_key         = max_ok_q ? max_q.key : '0;
		rsp_d.max_grade       = max_ok_q ? max_q.grade : '0;
	end
endmodule
`default_nettype wire

// File: rtl/core/sorted_key_table_with_max.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table_with_max
// Sorted key table with running highest-grade entry.
// ----------------------------------------------------------------------------
// usage:
//   req (req_valid/req_ready) carries one command per transaction; rsp
//   (rsp_valid/rsp_ready) returns exactly one result per command.
//   one command is worked on at a time; req_ready is high only when idle.
//   each command runs through S_DECODE, then a read and a step state per
//   entry for the delete scan and for the insert or delete shift, a step
//   and a read state per binary search step, then a read and an update
//   state per entry for the max rescan over count entries; the entry
//   memory serves one read per cycle.
//   the result sits in an output register; a stalled receiver holds it and
//   the next command is taken once the register is free.
//   reset clears the count; the max is rebuilt by every command and the
//   entry memory needs no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sorted_key_table_with_max #(
	parameter int TABLE_DEPTH = skt_pkg::TableDepthDefault
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire skt_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output skt_pkg::rsp_t      rsp
);
	skt_pkg::cmd_t cmd;
	skt_pkg::sts_t sts;
	skt_pkg::rsp_t rsp_d;
	logic          rsp_free;

	assign rsp_free = !rsp_valid || rsp_ready;

	skt_ctrl u_ctrl (
		.clk, .arst_n, .in_valid(req_valid), .in_ready(req_ready),
		.rsp_free, .sts, .cmd
	);

	skt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk, .arst_n, .req, .cmd, .sts, .rsp_d
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid <= 1'b0;
		else if (cmd.load_rsp) rsp_valid <= 1'b1;
		else if (rsp_ready) rsp_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rsp) rsp <= rsp_d;
	end

	`CHK_ALWAYS(a_rsp_held, clk, arst_n, !(cmd.load_rsp && rsp_valid && !rsp_ready), "result overwritten")
	`CHK_NEXT(a_req_busy, clk, arst_n, req_valid && req_ready, !req_ready, "second command taken")
	`CHK_ALWAYS(a_count_rng, clk, arst_n, rsp.count <= skt_pkg::PosW'(TABLE_DEPTH) || !rsp_valid, "count too big")
endmodule
`default_nettype wire

// File: dv/sorted_key_table_with_max_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_with_max_tb
// Drives random and directed table commands through the valid/ready request
// channel, predicts each result with a behavioural table model and compares
// every response field, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module sorted_key_table_with_max_tb;
	localparam int Depth = 64;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	skt_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	skt_pkg::rsp_t rsp;

	sorted_key_table_with_max #(.TABLE_DEPTH(Depth)) uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// predictor state
	logic [skt_pkg::KeyW-1:0]   tbl_key [Depth];
	logic                       tbl_hg [Depth];
	logic [skt_pkg::GradeW-1:0] tbl_grade [Depth];
	int                         tbl_count;

	skt_pkg::req_t pending_cmds[$];
	skt_pkg::rsp_t expected_rsps[$];
	int   errors;
	int   sent;
	bit   drain_hold;
	bit   stim_done;
	int   send_gap;
	int   stall_len;

	function automatic int find_key(logic [skt_pkg::KeyW-1:0] k);
		int lo, hi, mid;
		lo = 0;
		hi = tbl_count - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (k < tbl_key[mid]) hi = mid - 1;
			else if (k > tbl_key[mid]) lo = mid + 1;
			else return mid;
		end
		return -1;
	endfunction

	function automatic void put_entry(int idx, skt_pkg::req_t r);
		tbl_key[idx]   = r.key;
		tbl_hg[idx]    = r.has_grade;
		tbl_grade[idx] = r.has_grade ? r.grade : '0;
	endfunction

	function automatic skt_pkg::rsp_t apply_command(skt_pkg::req_t r);
		skt_pkg::rsp_t o;
		int i, f;
		bit found;
		o = '0;
		o.status = skt_pkg::ST_OK;
		case (r.command)
			skt_pkg::CMD_INSERT: begin
				if (tbl_count >= Depth) o.status = skt_pkg::ST_FULL;
				else begin
					i = tbl_count;
					while (i > 0 && !(r.key > tbl_key[i-1])) begin
						tbl_key[i] = tbl_key[i-1];
						tbl_hg[i] = tbl_hg[i-1];
						tbl_grade[i] = tbl_grade[i-1];
						i--;
					end
					put_entry(i, r);
					tbl_count++;
				end
			end
			skt_pkg::CMD_DELETE: begin
				i = 0;
				while (i < tbl_count && tbl_key[i] != r.key) i++;
				if (i >= tbl_count) o.status = skt_pkg::ST_NOKEY;
				else begin
					for (; i + 1 < tbl_count; i++) begin
						tbl_key[i] = tbl_key[i+1];
						tbl_hg[i] = tbl_hg[i+1];
						tbl_grade[i] = tbl_grade[i+1];
					end
					tbl_count--;
				end
			end
			skt_pkg::CMD_UPD_KEY: begin
				f = find_key(r.key);
				if (f < 0) o.status = skt_pkg::ST_NOKEY;
				else put_entry(f, r);
			end
			skt_pkg::CMD_UPD_IDX: begin
				if (r.position < 1 || r.position > tbl_count) o.status = skt_pkg::ST_BADINDEX;
				else put_entry(r.position - 1, r);
			end
			skt_pkg::CMD_LOOKUP: begin
				f = find_key(r.key);
				if (f < 0) o.status = skt_pkg::ST_NOKEY;
				else begin
					o.entry_key = tbl_key[f];
					o.entry_has_grade = tbl_hg[f];
					o.entry_grade = tbl_grade[f];
				end
			end
			skt_pkg::CMD_READ: begin
				if (r.position < 1 || r.position > tbl_count) o.status = skt_pkg::ST_BADINDEX;
				else begin
					o.entry_key = tbl_key[r.position-1];
					o.entry_has_grade = tbl_hg[r.position-1];
					o.entry_grade = tbl_grade[r.position-1];
				end
			end
			default: ;
		endcase
		// highest grade, smaller key on ties
		found = 0;
		f = 0;
		for (i = 0; i < tbl_count; i++) begin
			if (tbl_hg[i] && (!found || tbl_grade[i] > tbl_grade[f] ||
					(tbl_grade[i] == tbl_grade[f] && tbl_key[i] < tbl_key[f]))) begin
				found = 1;
				f = i;
			end
		end
		o.count = tbl_count[skt_pkg::PosW-1:0];
		o.max_valid = found;
		if (found) begin
			o.max_key = tbl_key[f];
			o.max_grade = tbl_grade[f];
		end
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// keys drawn from a small pool so lookups and deletes hit often
	logic [skt_pkg::KeyW-1:0] key_pool[16];

	function automatic skt_pkg::req_t rand_cmd(bit wide);
		skt_pkg::req_t r;
		int c;
		r.has_grade = 1'($urandom_range(0, 1));
		r.grade = wide ? skt_pkg::GradeW'($urandom()) :
			skt_pkg::GradeW'($urandom_range(0, 1000));
		r.position = wide ? skt_pkg::PosW'($urandom()) : skt_pkg::PosW'($urandom_range(0, 66));
		r.key = ($urandom_range(0, 3) == 0) ? skt_pkg::KeyW'($urandom()) :
			key_pool[$urandom_range(0, 15)];
		c = $urandom_range(0, 99);
		if (c < 30) r.command = skt_pkg::CMD_INSERT;
		else if (c < 45) r.command = skt_pkg::CMD_DELETE;
		else if (c < 58) r.command = skt_pkg::CMD_UPD_KEY;
		else if (c < 68) r.command = skt_pkg::CMD_UPD_IDX;
		else if (c < 82) r.command = skt_pkg::CMD_LOOKUP;
		else if (c < 96) r.command = skt_pkg::CMD_READ;
		else r.command = 3'($urandom_range(6, 7));
		return r;
	endfunction

	function automatic skt_pkg::req_t mk(logic [2:0] c, logic [skt_pkg::KeyW-1:0] k,
			logic [skt_pkg::PosW-1:0] p, logic hg, logic [skt_pkg::GradeW-1:0] g);
		skt_pkg::req_t r;
		r.command = c;
		r.key = k;
		r.position = p;
		r.has_grade = hg;
		r.grade = g;
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 0;
			req <= '0;
			send_gap <= 0;
		end else if (req_valid && !req_ready) begin
			// hold the transaction
		end else if (send_gap > 0) begin
			req_valid <= 0;
			send_gap <= send_gap - 1;
		end else if (pending_cmds.size() > 0 &&
				!(drain_hold && expected_rsps.size() > 0 && !(req_valid && req_ready))) begin
			req <= pending_cmds[0];
			req_valid <= 1;
			pending_cmds.pop_front();
			send_gap <= pick_gap();
		end else begin
			req_valid <= 0;
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin
		skt_pkg::rsp_t exp_r;
		if (!arst_n) begin
			rsp_ready <= 0;
			stall_len <= 0;
		end else begin
			if (req_valid && req_ready) begin
				expected_rsps.push_back(apply_command(req));
				sent <= sent + 1;
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected response %p", $realtime, rsp);
					errors <= errors + 1;
				end else begin
					exp_r = expected_rsps.pop_front();
					if (rsp !== exp_r) begin
						$display("%0t: mismatch expected %p actual %p", $realtime, exp_r, rsp);
						errors <= errors + 1;
					end
				end
			end
			if (stall_len > 0) begin
				rsp_ready <= 0;
				stall_len <= stall_len - 1;
			end else begin
				rsp_ready <= 1;
				stall_len <= pick_gap();
			end
		end
	end

	initial begin
		int i, guard;
		errors = 0;
		sent = 0;
		drain_hold = 0;
		stim_done = 0;
		tbl_count = 0;
		for (i = 0; i < 16; i++) key_pool[i] = skt_pkg::KeyW'($urandom_range(0, 99999999));
		key_pool[0] = '0;
		key_pool[1] = 27'd99999999;
		key_pool[2] = '1;
		arst_n = 0;
		req_valid = 0;
		req = '0;
		rsp_ready = 0;

		// directed: extremes, every command, each special case
		pending_cmds.push_back(mk(skt_pkg::CMD_READ, 0, 1, 0, 0));
		pending_cmds.push_back(mk(skt_pkg::CMD_DELETE, 5, 0, 0, 0));
		pending_cmds.push_back(mk(skt_pkg::CMD_LOOKUP, 5, 0, 0, 0));
		pending_cmds.push_back(mk(skt_pkg::CMD_INSERT, 27'd99999999, 0, 1, 10'd1000));
		pending_cmds.push_back(mk(skt_pkg::CMD_INSERT, 0, 0, 1, 10'd1000));
		pending_cmds.push_back(mk(skt_pkg::CMD_INSERT, 500, 0, 0, 10'd777));
		pending_cmds.push_back(mk(skt_pkg::CMD_INSERT, 500, 0, 1, 10'd3));
		pending_cmds.push_back(mk(skt_pkg::CMD_INSERT, '1, 0, 1, '1));
		pending_cmds.push_back(mk(skt_pkg::CMD_READ, 0, 0, 0, 0));
		pending_cmds.push_back(mk(skt_pkg::CMD_READ, 0, 7'd127, 0, 0));
		pending_cmds.push_back(mk(skt_pkg::CMD_READ, 0, 5, 0, 0));
		pending_cmds.push_back(mk(skt_pkg::CMD_READ, 0, 6, 0, 0));
		pending_cmds.push_back(mk(skt_pkg::CMD_LOOKUP, 500, 0, 0, 0));
		pending_cmds.push_back(mk(skt_pkg::CMD_UPD_KEY, 500, 0, 1, 10'd1000));
		pending_cmds.push_back(mk(skt_pkg::CMD_UPD_KEY, 501, 0, 1, 10'd1));
		pending_cmds.push_back(mk(skt_pkg::CMD_UPD_IDX, 3, 1, 1, 10'd5));
		pending_cmds.push_back(mk(skt_pkg::CMD_UPD_IDX, 3, 64, 1, 10'd5));
		pending_cmds.push_back(mk(skt_pkg::CMD_INSERT, 2, 0, 0, 0));
		pending_cmds.push_back(mk(skt_pkg::CMD_LOOKUP, 0, 0, 0, 0));
		pending_cmds.push_back(mk(3'd6, 1, 1, 1, 1));
		pending_cmds.push_back(mk(3'd7, 0, 0, 0, 0));
		pending_cmds.push_back(mk(skt_pkg::CMD_DELETE, 500, 0, 0, 0));
		pending_cmds.push_back(mk(skt_pkg::CMD_DELETE, 27'd99999999, 0, 0, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1;

		// fill to full, then overflow and drain
		for (i = 0; i < 66; i++)
			pending_cmds.push_back(mk(skt_pkg::CMD_INSERT,
				skt_pkg::KeyW'($urandom_range(0, 99999999)), 0,
				1'($urandom_range(0, 1)), skt_pkg::GradeW'($urandom_range(0, 1000))));
		for (i = 0; i < 8; i++) pending_cmds.push_back(rand_cmd(1));
		while (pending_cmds.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
		while (tbl_count > 8) begin
			pending_cmds.push_back(mk(skt_pkg::CMD_DELETE,
				tbl_key[$urandom_range(0, tbl_count-1)], 0, 0, 0));
			while (pending_cmds.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
		end

		for (i = 0; i < 1100; i++) begin
			pending_cmds.push_back(rand_cmd($urandom_range(0, 7) == 0));
			if (i == 550) begin
				// pause sending until everything has returned
				while (pending_cmds.size() > 0) @(posedge clk);
				drain_hold = 1;
				pending_cmds.push_back(rand_cmd(0));
				while (pending_cmds.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
				drain_hold = 0;
			end
			while (pending_cmds.size() > 4) @(posedge clk);
		end

		guard = 0;
		while ((pending_cmds.size() > 0 || req_valid || expected_rsps.size() > 0)
				&& guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		if (guard >= 200000) begin
			$display("Some tests failed");
			$finish;
		end
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
